/* hdl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int BITS_PER_BYTE = 8;

    localparam int HALF_W    = 16;
    localparam int TIMEOUT_W = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    // Command codes carried by each input transfer.
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_WAIT_ACK = 3'd5
    } cmd_t;

    // One input item as unpacked from the stream.
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // One result item: line drive and status after a tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } result_t;

endpackage

/* hdl/i2cmbe_core.sv */
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer: advances the I2C waveform state by one tick per step.
// ----------------------------------------------------------------------------
module i2cmbe_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  i2cmbe_pkg::item_t                      item,
    input  logic                                   cfg_we,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [i2cmbe_pkg::CFG_W-1:0]           cfg_data,
    output i2cmbe_pkg::result_t                    result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_STOP,
        PH_WRITE,
        PH_READ,
        PH_ACK,
        PH_TSTOP
    } phase_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic en;
    } line_t;

    localparam logic [3:0] LAST_BIT = 4'(i2cmbe_pkg::BITS_PER_BYTE);

    phase_t                               phase_reg, phase_next;
    logic [3:0]                           bit_reg, bit_next;
    logic [7:0]                           shift_reg, shift_next;
    logic [i2cmbe_pkg::HALF_W-1:0]        delay_reg, delay_next;
    logic [7:0]                           poll_reg, poll_next;
    line_t                                line_reg, line_next;
    logic [7:0]                           rdata_reg, rdata_next;
    logic                                 miss_reg, miss_next;
    logic                                 done_reg, done_next;
    logic [i2cmbe_pkg::HALF_W-1:0]        half_reg;
    logic [i2cmbe_pkg::TIMEOUT_W-1:0]     timeout_reg;

    logic [i2cmbe_pkg::HALF_W-1:0]        half_eff;
    logic [i2cmbe_pkg::TIMEOUT_W-1:0]     timeout_eff;
    logic [7:0]                           poll_inc;
    logic [3:0]                           bit_inc;

    assign half_eff    = (half_reg == '0) ? i2cmbe_pkg::HALF_W'(1) : half_reg;
    assign timeout_eff = (timeout_reg == '0) ? i2cmbe_pkg::TIMEOUT_W'(1) : timeout_reg;
    assign poll_inc    = poll_reg + 8'd1;
    assign bit_inc     = bit_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= i2cmbe_pkg::HALF_RESET;
            timeout_reg <= i2cmbe_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cmbe_pkg::CFG_HALF_PERIOD: half_reg    <= cfg_data;
                i2cmbe_pkg::CFG_ACK_TIMEOUT: timeout_reg <= cfg_data[i2cmbe_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        line_next  = line_reg;
        rdata_next = rdata_reg;
        miss_next  = miss_reg;
        done_next  = done_reg;

        if (step)
        begin
            done_next = 1'b0;
            if (phase_reg == PH_IDLE)
            begin
                bit_next = 4'd0;
                case (i2cmbe_pkg::cmd_t'(item.command))
                    i2cmbe_pkg::CMD_START:
                    begin
                        phase_next = PH_START;
                        line_next  = '{1'b1, 1'b1, 1'b1};
                        delay_next = 16'd1;
                    end
                    i2cmbe_pkg::CMD_STOP:
                    begin
                        phase_next = PH_STOP;
                        line_next  = '{1'b0, 1'b0, 1'b1};
                        delay_next = 16'd1;
                    end
                    i2cmbe_pkg::CMD_WRITE:
                    begin
                        phase_next = PH_WRITE;
                        shift_next = item.write_byte;
                        line_next  = '{1'b0, item.write_byte[7], 1'b1};
                        delay_next = 16'd1;
                    end
                    i2cmbe_pkg::CMD_READ:
                    begin
                        phase_next = PH_READ;
                        shift_next = 8'd0;
                        // The ACK choice rides in the poll counter during a read.
                        poll_next  = {7'd0, item.send_ack};
                        line_next  = '{1'b0, 1'b1, 1'b0};
                        delay_next = 16'd1;
                    end
                    i2cmbe_pkg::CMD_WAIT_ACK:
                    begin
                        phase_next = PH_ACK;
                        poll_next  = 8'd0;
                        miss_next  = 1'b0;
                        line_next  = '{1'b0, 1'b1, 1'b0};
                        delay_next = 16'd1;
                    end
                    default: ;
                endcase
            end
            else if (delay_reg < half_eff)
            begin
                delay_next = delay_reg + 16'd1;
            end
            else if (phase_reg == PH_ACK && bit_reg == 4'd1)
            begin
                // Polling SDA with SCL high.
                if (!item.sda_in)
                begin
                    line_next  = '{1'b0, 1'b1, 1'b0};
                    delay_next = 16'd0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    poll_next = poll_inc;
                    if (poll_inc >= timeout_eff)
                    begin
                        phase_next = PH_TSTOP;
                        bit_next   = 4'd0;
                        line_next  = '{1'b0, 1'b0, 1'b1};
                        delay_next = 16'd1;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (bit_reg == 4'd0)
                        begin
                            bit_next   = 4'd1;
                            line_next  = '{1'b1, 1'b0, 1'b1};
                            delay_next = 16'd1;
                        end
                        else
                        begin
                            line_next  = '{1'b0, 1'b0, 1'b1};
                            delay_next = 16'd0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    PH_STOP, PH_TSTOP:
                    begin
                        if (bit_reg == 4'd0)
                        begin
                            bit_next   = 4'd1;
                            line_next  = '{1'b1, 1'b0, 1'b1};
                            delay_next = 16'd1;
                        end
                        else
                        begin
                            if (phase_reg == PH_TSTOP)
                            begin
                                miss_next = 1'b1;
                            end
                            line_next  = '{1'b1, 1'b1, 1'b1};
                            delay_next = 16'd0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    PH_ACK:
                    begin
                        bit_next   = 4'd1;
                        line_next  = '{1'b1, 1'b1, 1'b0};
                        delay_next = 16'd1;
                    end
                    PH_WRITE:
                    begin
                        if (!line_reg.scl)
                        begin
                            line_next  = '{1'b1, line_reg.sda, 1'b1};
                            delay_next = 16'd1;
                        end
                        else if (bit_inc < LAST_BIT)
                        begin
                            bit_next   = bit_inc;
                            shift_next = {shift_reg[6:0], 1'b0};
                            line_next  = '{1'b0, shift_reg[6], 1'b1};
                            delay_next = 16'd1;
                        end
                        else
                        begin
                            line_next  = '{1'b0, line_reg.sda, 1'b1};
                            delay_next = 16'd0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    PH_READ:
                    begin
                        if (bit_reg < LAST_BIT)
                        begin
                            if (!line_reg.scl)
                            begin
                                line_next  = '{1'b1, 1'b1, 1'b0};
                                delay_next = 16'd1;
                            end
                            else
                            begin
                                shift_next = {shift_reg[6:0], item.sda_in};
                                bit_next   = bit_inc;
                                delay_next = 16'd1;
                                if (bit_inc < LAST_BIT)
                                begin
                                    line_next = '{1'b0, 1'b1, 1'b0};
                                end
                                else
                                begin
                                    line_next = '{1'b0, ~poll_reg[0], 1'b1};
                                end
                            end
                        end
                        else if (!line_reg.scl)
                        begin
                            line_next  = '{1'b1, line_reg.sda, 1'b1};
                            delay_next = 16'd1;
                        end
                        else
                        begin
                            rdata_next = shift_reg;
                            line_next  = '{1'b0, line_reg.sda, 1'b1};
                            delay_next = 16'd0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= '0;
            poll_reg  <= 8'd0;
            line_reg  <= '{1'b1, 1'b1, 1'b0};
            rdata_reg <= 8'd0;
            miss_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            line_reg  <= line_next;
            rdata_reg <= rdata_next;
            miss_reg  <= miss_next;
            done_reg  <= done_next;
        end
    end

    assign result = '{
        scl_level:   line_reg.scl,
        sda_level:   line_reg.sda,
        sda_enable:  line_reg.en,
        busy_res:    (phase_reg != PH_IDLE),
        done_res:    done_reg,
        read_data:   rdata_reg,
        ack_missing: miss_reg
    };

    // A completed command always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (phase_reg == PH_IDLE))
        else $error("done raised while a command is still running");

    // The bit counter never passes one byte.
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= LAST_BIT)
        else $error("bit counter beyond byte length");

    // Without a step the bus state holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(line_reg) && $stable(delay_reg)))
        else $error("state changed without a step");

    // Taking a wait-ack command clears the missing-ACK flag.
    a_ack_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && item.command == i2cmbe_pkg::CMD_WAIT_ACK)
        |=> !miss_reg)
        else $error("ack_missing not cleared by wait ack");

    // done lasts exactly one step.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && step) |=> !done_reg)
        else $error("done held over two steps");

endmodule

/* hdl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master that produces SCL/SDA waveforms, one transfer per timer tick.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the bus timer. It carries an optional
// command (start, stop, write byte, read byte, wait for ACK) and the SDA level
// sampled on the bus. Every accepted input transfer produces exactly one
// output transfer with the SCL level, the SDA drive and enable, busy, a
// one-tick done pulse, the last read byte and the ACK-missing flag.
// The sequencer state registers double as the output register, so the
// result is valid on the cycle after the input transfer is accepted.
// s_axis_tready stays high while the result is taken or the output is empty,
// so a new tick is accepted every cycle (one transfer per cycle) unless the
// receiver stalls; a stalled receiver holds the input off by one stage and
// nothing is lost or repeated. Reset leaves the engine idle with SCL high,
// SDA released and both delay registers at their defaults (half period 10
// ticks, ACK timeout 250 polls). Configuration is to be written by the user
// through cfg_we/cfg_index/cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    // command[2:0], write_byte[10:3], send_ack[11], sda_in[12]
    input  logic [15:0]                         s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // scl_level[0], sda_level[1], sda_enable[2], busy_res[3], done_res[4],
    // read_data[12:5], ack_missing[13]
    output logic [15:0]                         m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cmbe_pkg::CFG_W-1:0]        cfg_data
);

    logic                   out_valid_reg, out_valid_next;
    logic                   step;
    i2cmbe_pkg::item_t      item;
    i2cmbe_pkg::result_t    result;

    // A transfer is taken whenever the output slot is free or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    assign item = '{
        command:    s_axis_tdata[2:0],
        write_byte: s_axis_tdata[10:3],
        send_ack:   s_axis_tdata[11],
        sda_in:     s_axis_tdata[12]
    };

    i2cmbe_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result.ack_missing, result.read_data,
                            result.done_res, result.busy_res, result.sda_enable,
                            result.sda_level, result.scl_level};

endmodule

/* tb/i2c_master_bit_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_test
// Self-checking testbench for the I2C master bit engine.
// ----------------------------------------------------------------------------
// Every input transfer is one timer tick and yields exactly one result
// transfer. A behavioral copy of the engine runs alongside the design. It is
// stepped on each accepted tick, and its line drive and status are queued and
// compared field by field with the results as they leave the design. A short
// table of commands comes first, run with both delay registers at zero. Then
// bus transactions with random content run under several register settings,
// mixed with stray and illegal commands. A start with the longest half period
// closes the run; only its first ticks are sent, since the command itself
// would take far longer than the rest of the run.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_test;

    import i2cmbe_pkg::*;

    // Command codes that the engine must treat like no command.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Results that can be read straight off the engine's behavior.
    localparam result_t LINES_AT_RESET = '{scl_level: 1'b1, sda_level: 1'b1,
        sda_enable: 1'b0, busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00,
        ack_missing: 1'b0};
    localparam result_t ACK_TIMED_OUT = '{scl_level: 1'b1, sda_level: 1'b1,
        sda_enable: 1'b1, busy_res: 1'b0, done_res: 1'b1, read_data: 8'h00,
        ack_missing: 1'b1};
    localparam result_t ACK_SEEN = '{scl_level: 1'b0, sda_level: 1'b1,
        sda_enable: 1'b0, busy_res: 1'b0, done_res: 1'b1, read_data: 8'h00,
        ack_missing: 1'b0};

    // Sequencer phases of the behavioral engine.
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_START,
        ENG_STOP,
        ENG_WRITE,
        ENG_READ,
        ENG_ACK,
        ENG_ACK_STOP
    } eng_phase_e;

    // SDA behavior of the bus while a command runs.
    typedef enum logic [1:0] {
        SDA_RANDOM,
        SDA_HELD_HIGH,
        SDA_HELD_LOW
    } sda_mode_e;

    // One row of the command table. The expected result, where given,
    // applies to the tick on which the command completes.
    typedef struct {
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
        bit         has_want;
        result_t    want;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Behavioral engine state, starting from its reset values.
    eng_phase_e      eng_phase = ENG_IDLE;
    logic [3:0]      bit_cnt = '0;
    logic [7:0]      shreg = '0;
    logic [15:0]     dly = '0;
    logic [7:0]      polls = '0;
    logic            scl_q = 1'b1;
    logic            sda_q = 1'b1;
    logic            oe_q = 1'b0;
    logic            done_q = 1'b0;
    logic [7:0]      rx_byte = '0;
    logic            nack_q = 1'b0;
    logic [HALF_W-1:0]    half_q = HALF_RESET;
    logic [TIMEOUT_W-1:0] tmo_q = TIMEOUT_RESET;

    result_t   expected_drive[$];
    cmd_row_t  cmd_table[$];
    int        mismatches = 0;

    // Stimulus state: the bus transaction in progress and the SDA behavior.
    bit        in_txn = 1'b0;
    cmd_t      last_cmd = CMD_NONE;
    sda_mode_e sda_mode = SDA_RANDOM;
    bit        send_calm = 1'b0;
    bit        take_calm = 1'b0;
    bit        steady_run = 1'b0;

    i2c_master_bit_engine u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A new bus step: set the lines and restart the half-period count.
    function automatic void put_lines(logic scl, logic sda, logic oe);
        scl_q = scl;
        sda_q = sda;
        oe_q  = oe;
        dly   = 16'd1;
    endfunction

    // Last bus step of a command: the engine goes idle and pulses done.
    function automatic void end_command(logic scl, logic sda, logic oe);
        put_lines(scl, sda, oe);
        dly       = '0;
        eng_phase = ENG_IDLE;
        done_q    = 1'b1;
    endfunction

    // Moves the running command on by one bus step once its delay is over.
    function automatic void bus_step(logic sda_in);
        case (eng_phase)
            ENG_START:
            begin
                if (bit_cnt == 0)
                begin
                    bit_cnt = 4'd1;
                    put_lines(1'b1, 1'b0, 1'b1);
                end
                else
                    end_command(1'b0, 1'b0, 1'b1);
            end
            ENG_STOP, ENG_ACK_STOP:
            begin
                if (bit_cnt == 0)
                begin
                    bit_cnt = 4'd1;
                    put_lines(1'b1, 1'b0, 1'b1);
                end
                else
                begin
                    // The stop that follows a missing ACK raises the flag
                    // only once the bus is released.
                    if (eng_phase == ENG_ACK_STOP)
                        nack_q = 1'b1;
                    end_command(1'b1, 1'b1, 1'b1);
                end
            end
            ENG_ACK:
            begin
                bit_cnt = 4'd1;
                put_lines(1'b1, 1'b1, 1'b0);
            end
            ENG_WRITE:
            begin
                if (!scl_q)
                    put_lines(1'b1, sda_q, 1'b1);
                else if (bit_cnt + 1 < BITS_PER_BYTE)
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    shreg   = shreg << 1;
                    put_lines(1'b0, shreg[7], 1'b1);
                end
                else
                    end_command(1'b0, sda_q, 1'b1);
            end
            ENG_READ:
            begin
                if (bit_cnt < BITS_PER_BYTE)
                begin
                    if (!scl_q)
                        put_lines(1'b1, 1'b1, 1'b0);
                    else
                    begin
                        // SDA is taken at the end of the SCL high step.
                        shreg   = {shreg[6:0], sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE)
                            put_lines(1'b0, 1'b1, 1'b0);
                        else
                            put_lines(1'b0, ~polls[0], 1'b1);
                    end
                end
                else if (!scl_q)
                    put_lines(1'b1, sda_q, 1'b1);
                else
                begin
                    rx_byte = shreg;
                    end_command(1'b0, sda_q, 1'b1);
                end
            end
            default:
                eng_phase = ENG_IDLE;
        endcase
    endfunction

    // Processes one timer tick and returns the lines and status after it.
    function automatic result_t engine_tick(item_t it);
        logic [HALF_W-1:0]    half;
        logic [TIMEOUT_W-1:0] limit;
        result_t              r;
        half   = (half_q == 0) ? 16'd1 : half_q;
        limit  = (tmo_q == 0) ? 8'd1 : tmo_q;
        done_q = 1'b0;
        if (eng_phase == ENG_IDLE)
        begin
            bit_cnt = '0;
            case (it.command)
                CMD_START:
                begin
                    eng_phase = ENG_START;
                    put_lines(1'b1, 1'b1, 1'b1);
                end
                CMD_STOP:
                begin
                    eng_phase = ENG_STOP;
                    put_lines(1'b0, 1'b0, 1'b1);
                end
                CMD_WRITE:
                begin
                    eng_phase = ENG_WRITE;
                    shreg     = it.write_byte;
                    put_lines(1'b0, it.write_byte[7], 1'b1);
                end
                CMD_READ:
                begin
                    // The ACK choice is parked in the poll counter.
                    eng_phase = ENG_READ;
                    shreg     = '0;
                    polls     = {7'd0, it.send_ack};
                    put_lines(1'b0, 1'b1, 1'b0);
                end
                CMD_WAIT_ACK:
                begin
                    eng_phase = ENG_ACK;
                    polls     = '0;
                    nack_q    = 1'b0;
                    put_lines(1'b0, 1'b1, 1'b0);
                end
                default:
                    ;
            endcase
        end
        else if (dly < half)
            dly = dly + 16'd1;
        else if (eng_phase == ENG_ACK && bit_cnt == 1)
        begin
            // SCL is high: poll SDA until the slave pulls it low.
            if (!it.sda_in)
                end_command(1'b0, 1'b1, 1'b0);
            else
            begin
                polls = polls + 8'd1;
                if (polls >= limit)
                begin
                    eng_phase = ENG_ACK_STOP;
                    bit_cnt   = '0;
                    put_lines(1'b0, 1'b0, 1'b1);
                end
            end
        end
        else
            bus_step(it.sda_in);
        r.scl_level   = scl_q;
        r.sda_level   = sda_q;
        r.sda_enable  = oe_q;
        r.busy_res    = (eng_phase != ENG_IDLE);
        r.done_res    = done_q;
        r.read_data   = rx_byte;
        r.ack_missing = nack_q;
        return r;
    endfunction

    // Chooses the next tick. An idle engine mostly gets the next command of
    // a well-formed transaction; the rest are stray or illegal codes. A busy
    // engine gets any code, which it has to ignore.
    function automatic item_t pick_tick(bit may_issue);
        item_t it;
        int    pick;
        it.write_byte = 8'($urandom_range(0, 255));
        it.send_ack   = 1'($urandom_range(0, 1));
        if (eng_phase != ENG_IDLE)
            it.command = 3'($urandom_range(0, 7));
        else if (!may_issue)
            it.command = CMD_NONE;
        else if ($urandom_range(0, 99) < 15)
            it.command = 3'($urandom_range(0, 7));
        else
        begin
            pick = $urandom_range(0, 2);
            if (!in_txn)
                last_cmd = CMD_START;
            else
            begin
                case (last_cmd)
                    CMD_START:
                        last_cmd = CMD_WRITE;
                    CMD_WRITE:
                        last_cmd = CMD_WAIT_ACK;
                    CMD_WAIT_ACK:
                        last_cmd = (pick == 0) ? CMD_WRITE :
                                   (pick == 1) ? CMD_READ : CMD_STOP;
                    CMD_READ:
                        last_cmd = (pick == 2) ? CMD_STOP : CMD_READ;
                    default:
                        last_cmd = CMD_STOP;
                endcase
            end
            in_txn     = (last_cmd != CMD_STOP);
            it.command = last_cmd;
        end
        // A new command sets how the slave side behaves on SDA. An ACK poll
        // may see a prompt ACK, a late one, or none at all.
        if (eng_phase == ENG_IDLE)
        begin
            if (it.command == CMD_WAIT_ACK)
                sda_mode = sda_mode_e'($urandom_range(0, 2));
            else
                sda_mode = SDA_RANDOM;
        end
        case (sda_mode)
            SDA_HELD_HIGH:
                it.sda_in = 1'b1;
            SDA_HELD_LOW:
                it.sda_in = 1'b0;
            default:
                it.sda_in = 1'($urandom_range(0, 1));
        endcase
        return it;
    endfunction

    // Offers one tick after a random gap and, once it is taken, queues the
    // expected result. A typed result replaces the predicted one on the tick
    // where the command completes.
    task automatic send_tick(input item_t it, input bit use_typed, input result_t typed);
        int unsigned gap;
        result_t     want;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = (send_calm || steady_run) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {3'b000, it.sda_in, it.send_ack, it.write_byte, it.command};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = engine_tick(it);
        if (use_typed && eng_phase == ENG_IDLE)
            expected_drive.push_back(typed);
        else
            expected_drive.push_back(want);
    endtask

    // Runs the engine out of its current command and waits until every
    // result has been taken, so that the registers may be written.
    task automatic settle();
        while (eng_phase != ENG_IDLE)
            send_tick(pick_tick(1'b0), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [HALF_W-1:0] half, input logic [TIMEOUT_W-1:0] limit);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= half;
        @(posedge clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= {8'h00, limit};
        @(posedge clk);
        cfg_we <= 1'b0;
        half_q = half;
        tmo_q  = limit;
    endtask

    task automatic run_phase(input logic [HALF_W-1:0] half, input logic [TIMEOUT_W-1:0] limit,
                             input int ticks);
        set_config(half, limit);
        repeat (ticks)
            send_tick(pick_tick(1'b1), 1'b0, '0);
    endtask

    function automatic void add_row(logic [2:0] command, logic [7:0] write_byte,
                                    logic send_ack, logic sda_in, bit has_want,
                                    result_t want);
        cmd_row_t row;
        row.command    = command;
        row.write_byte = write_byte;
        row.send_ack   = send_ack;
        row.sda_in     = sda_in;
        row.has_want   = has_want;
        row.want       = want;
        cmd_table.push_back(row);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: stall at random, and compare each transfer with the
    // oldest expectation.
    initial
    begin : take_results
        int unsigned stall;
        result_t     want;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            stall = (take_calm || steady_run) ? 0 : $urandom_range(0, 18);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
            if (expected_drive.size() == 0)
            begin
                $error("result transfer 0x%h with no tick outstanding", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_drive.pop_front();
                check_field("scl_level", want.scl_level, m_axis_tdata[0]);
                check_field("sda_level", want.sda_level, m_axis_tdata[1]);
                check_field("sda_enable", want.sda_enable, m_axis_tdata[2]);
                check_field("busy_res", want.busy_res, m_axis_tdata[3]);
                check_field("done_res", want.done_res, m_axis_tdata[4]);
                check_field("read_data", want.read_data, m_axis_tdata[12:5]);
                check_field("ack_missing", want.ack_missing, m_axis_tdata[13]);
            end
        end
    end

    initial
    begin : run_stimulus
        item_t it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in either register must act as one, which also keeps the
        // table short: every bus step lasts a single tick.
        set_config(16'd0, 8'd0);

        // Illegal codes and no command leave the reset state untouched. An
        // ACK poll that sees SDA high times out into a stop; one that sees it
        // low ends with SCL low and SDA released. Then a full transaction with
        // all-zero, all-one and mixed bytes, ACK and NACK reads, and a second
        // one whose ACK goes missing before a read.
        add_row(CMD_SPARE_6,  8'h00, 1'b0, 1'b1, 1'b1, LINES_AT_RESET);
        add_row(CMD_SPARE_7,  8'hFF, 1'b1, 1'b0, 1'b1, LINES_AT_RESET);
        add_row(CMD_NONE,     8'h00, 1'b0, 1'b0, 1'b1, LINES_AT_RESET);
        add_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b1, ACK_TIMED_OUT);
        add_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b1, ACK_SEEN);
        add_row(CMD_START,    8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_WRITE,    8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_WRITE,    8'hFF, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_WRITE,    8'hA5, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_READ,     8'h00, 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_READ,     8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_STOP,     8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_START,    8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_WRITE,    8'h5A, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_READ,     8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(CMD_STOP,     8'h00, 1'b1, 1'b0, 1'b0, '0);

        // Each row's command is issued once; random codes follow while the
        // engine is busy and must have no effect.
        foreach (cmd_table[i])
        begin
            it.command    = cmd_table[i].command;
            it.write_byte = cmd_table[i].write_byte;
            it.send_ack   = cmd_table[i].send_ack;
            it.sda_in     = cmd_table[i].sda_in;
            send_tick(it, cmd_table[i].has_want, cmd_table[i].want);
            while (eng_phase != ENG_IDLE)
            begin
                it.command    = 3'($urandom_range(0, 7));
                it.write_byte = 8'($urandom_range(0, 255));
                it.send_ack   = 1'($urandom_range(0, 1));
                send_tick(it, cmd_table[i].has_want, cmd_table[i].want);
            end
        end

        // Random transactions under several settings, the default values
        // among them, down to the shortest steps and up to the longest poll.
        run_phase(16'd10, 8'd250, 120);
        run_phase(16'd1,  8'd1,   120);
        run_phase(16'd2,  8'd7,   120);
        run_phase(16'd0,  8'd255, 115);
        run_phase(16'd3,  8'd0,   115);
        run_phase(16'd1,  8'd12,  115);

        // Longest half period: a start and the first ticks of its opening
        // bus step. The command is left running; the run ends once every
        // result has been checked.
        steady_run = 1'b1;
        set_config(16'hFFFF, 8'd4);
        it.command    = CMD_START;
        it.write_byte = 8'h00;
        it.send_ack   = 1'b0;
        it.sda_in     = 1'b1;
        send_tick(it, 1'b0, '0);
        repeat (20)
            send_tick(pick_tick(1'b0), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : run_limit
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_core.sv
hdl/i2c_master_bit_engine.sv
tb/i2c_master_bit_engine_test.sv
